FILE: rtl/core/multi_channel_message_queue_unit_assert.svh
// Assertion macros used by the message queue datapath.
`ifndef MULTI_CHANNEL_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MCMQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MCMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mcmq_pkg.sv
// Shared types and constants of the multi-channel message queue.
package mcmq_pkg;

    localparam int CH_FIELD_W = 4;
    localparam int MSG_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int TDATA_W    = 16;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DELIVERED    = 3'd0,
        ST_QUEUED       = 3'd1,
        ST_WAITING      = 3'd2,
        ST_BAD_CHANNEL  = 3'd3,
        ST_QUEUE_FULL   = 3'd4,
        ST_WAITERS_FULL = 3'd5
    } t_status;

    // Operation kinds.
    localparam logic KIND_SEND    = 1'b0;
    localparam logic KIND_RECEIVE = 1'b1;

    // Conditions reported by the datapath for the held transaction.
    typedef struct packed {
        logic kind;
        logic bad;
        logic wait_nz;
        logic wait_max;
        logic q_full;
        logic q_empty;
        logic out_free;
    } t_dp_status;

    // Commands issued by the controller.
    typedef struct packed {
        logic    load_item;
        logic    send_direct;
        logic    enqueue;
        logic    dequeue;
        logic    add_waiter;
        logic    load_out;
        logic    load_out_mem;
        t_status code;
    } t_dp_cmd;

endpackage

FILE: rtl/core/multi_channel_message_queue_unit.sv
// Top level of the multi-channel message queue.
// Path from input transaction to result: the held-transaction register, then the result
// register for sends, bad channels and blocked receives; a receive that pops a byte also
// passes the registered store read. No new transaction is taken until the last one has been
// evaluated and any store read done; a stalled result holds evaluation of the next one.
// Reset (synchronous, active low) clears all pointers, fill and waiting counts and the
// result valid flag; the store needs no clearing, as it is read only once written.
module multi_channel_message_queue_unit #(
    parameter int CHANNELS    = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_WAITERS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: [3:0] channel, [11:4] message, [15:12] zero
    input  logic [mcmq_pkg::TDATA_W-1:0]  s_tdata,
    // s_tuser: [0] kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: [3:0] out_channel, [11:4] out_message, [15:12] zero
    output logic [mcmq_pkg::TDATA_W-1:0]  m_tdata,
    // m_tuser: [2:0] status
    output logic [mcmq_pkg::STATUS_W-1:0] m_tuser
);
    import mcmq_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    // Controller.
    mcmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // Datapath.
    mcmq_datapath #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_WAITERS (MAX_WAITERS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cmd      (cmd),
        .o_status   (dp_status)
    );

endmodule

FILE: rtl/core/mcmq_ctrl.sv
// Controller state machine of the multi-channel message queue.
module mcmq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  mcmq_pkg::t_dp_status i_status,
    output mcmq_pkg::t_dp_cmd   o_cmd
);
    import mcmq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.code = ST_DELIVERED;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No transaction is taken while reset is held.
                o_s_tready = i_rst_n;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                // Act only once the output register can take the result.
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                    if (i_status.bad) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.code     = ST_BAD_CHANNEL;
                    end else if (i_status.kind == KIND_SEND) begin
                        o_cmd.load_out = 1'b1;
                        if (i_status.wait_nz) begin
                            o_cmd.send_direct = 1'b1;
                            o_cmd.code        = ST_DELIVERED;
                        end else if (i_status.q_full) begin
                            o_cmd.code = ST_QUEUE_FULL;
                        end else begin
                            o_cmd.enqueue = 1'b1;
                            o_cmd.code    = ST_QUEUED;
                        end
                    end else if (!i_status.q_empty) begin
                        o_cmd.dequeue = 1'b1;
                        n_state       = S_READ;
                    end else if (i_status.wait_max) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.code     = ST_WAITERS_FULL;
                    end else begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.add_waiter = 1'b1;
                        o_cmd.code       = ST_WAITING;
                    end
                end
            end
            S_READ: begin
                o_cmd.load_out_mem = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/mcmq_datapath.sv
// Datapath of the multi-channel message queue: channel state, store and result register.
module mcmq_datapath #(
    parameter int CHANNELS    = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_WAITERS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [mcmq_pkg::TDATA_W-1:0]     i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [mcmq_pkg::TDATA_W-1:0]     o_m_tdata,
    output logic [mcmq_pkg::STATUS_W-1:0]    o_m_tuser,
    input  mcmq_pkg::t_dp_cmd                i_cmd,
    output mcmq_pkg::t_dp_status             o_status
);
    import mcmq_pkg::*;

    `include "multi_channel_message_queue_unit_assert.svh"

    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int WT_W    = $clog2(MAX_WAITERS + 1);
    localparam int DEPTH   = CHANNELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PAD_W   = TDATA_W - CH_FIELD_W - MSG_W;

    // Held transaction.
    logic                  r_kind;
    logic [CH_FIELD_W-1:0] r_channel;
    logic [MSG_W-1:0]      r_message;

    // Per-channel state.
    logic [PTR_W-1:0] r_rd_ptr [CHANNELS];
    logic [PTR_W-1:0] r_wr_ptr [CHANNELS];
    logic [CNT_W-1:0] r_fill   [CHANNELS];
    logic [WT_W-1:0]  r_wait   [CHANNELS];

    // Shared message store.
    logic [MSG_W-1:0] r_store [DEPTH];
    logic [MSG_W-1:0] r_rd_data;

    // Result register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [CH_FIELD_W-1:0] r_out_channel;
    logic [MSG_W-1:0]      r_out_message;

    logic [CH_W-1:0]   ch_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_next;

    assign ch_idx = r_channel[CH_W-1:0];

    // Store addresses: channel slice base plus pointer.
    assign wr_addr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_wr_ptr[ch_idx]));
    assign rd_addr = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_rd_ptr[ch_idx]));

    // Pointer advance with wrap at the end of the slice.
    assign wr_next = (r_wr_ptr[ch_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     PTR_W'(r_wr_ptr[ch_idx] + 1'b1);
    assign rd_next = (r_rd_ptr[ch_idx] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     PTR_W'(r_rd_ptr[ch_idx] + 1'b1);

    // Conditions for the controller.
    always_comb begin
        o_status.kind     = r_kind;
        o_status.bad      = ({1'b0, r_channel} >= (CH_FIELD_W + 1)'(CHANNELS));
        o_status.wait_nz  = (r_wait[ch_idx] != '0);
        o_status.wait_max = (r_wait[ch_idx] == WT_W'(MAX_WAITERS));
        o_status.q_full   = (r_fill[ch_idx] == CNT_W'(QUEUE_DEPTH));
        o_status.q_empty  = (r_fill[ch_idx] == '0);
        o_status.out_free = !r_out_valid || i_m_tready;
    end

    // Capture of an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_SEND;
            r_channel <= '0;
            r_message <= '0;
        end else if (i_cmd.load_item) begin
            r_kind    <= i_s_tuser;
            r_channel <= i_s_tdata[CH_FIELD_W-1:0];
            r_message <= i_s_tdata[CH_FIELD_W +: MSG_W];
        end
    end

    // Pointers, fill counts and waiting counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rd_ptr[i] <= '0;
                r_wr_ptr[i] <= '0;
                r_fill[i]   <= '0;
                r_wait[i]   <= '0;
            end
        end else begin
            if (i_cmd.enqueue) begin
                r_wr_ptr[ch_idx] <= wr_next;
                r_fill[ch_idx]   <= CNT_W'(r_fill[ch_idx] + 1'b1);
            end
            if (i_cmd.dequeue) begin
                r_rd_ptr[ch_idx] <= rd_next;
                r_fill[ch_idx]   <= CNT_W'(r_fill[ch_idx] - 1'b1);
            end
            if (i_cmd.send_direct) begin
                r_wait[ch_idx] <= WT_W'(r_wait[ch_idx] - 1'b1);
            end
            if (i_cmd.add_waiter) begin
                r_wait[ch_idx] <= WT_W'(r_wait[ch_idx] + 1'b1);
            end
        end
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.enqueue) begin
            r_store[wr_addr] <= r_message;
        end
        if (i_cmd.dequeue) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Result register: valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out || i_cmd.load_out_mem) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= i_cmd.code;
            r_out_channel <= r_channel;
            r_out_message <= i_cmd.send_direct ? r_message : '0;
        end else if (i_cmd.load_out_mem) begin
            r_out_status  <= ST_DELIVERED;
            r_out_channel <= r_channel;
            r_out_message <= r_rd_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_message, r_out_channel};
    assign o_m_tuser  = r_out_status;

    // A channel never holds queued bytes and waiting receivers at once.
    `MCMQ_ASSERT_IMP(a_fill_xor_wait, i_clk, i_rst_n, !o_status.bad && !o_status.q_empty,
        !o_status.wait_nz, "channel holds bytes and waiting receivers together")

    // Bytes are queued only into a valid channel that has room and no waiter.
    `MCMQ_ASSERT_IMP(a_enqueue_legal, i_clk, i_rst_n, i_cmd.enqueue,
        !o_status.bad && !o_status.q_full && !o_status.wait_nz, "illegal enqueue")

    // A store read is always followed by loading its data into the result.
    `MCMQ_ASSERT_NEXT(a_read_then_load, i_clk, i_rst_n, i_cmd.dequeue,
        i_cmd.load_out_mem && !r_out_valid, "store read not followed by result load")

    // A new result is never loaded over one that is still waiting.
    `MCMQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out || i_cmd.load_out_mem,
        !r_out_valid || i_m_tready, "result overwritten before transfer")

endmodule

FILE: tb/multi_channel_message_queue_unit_test.sv
// Self-checking testbench of the multi-channel message queue: directed table, then random traffic.
module multi_channel_message_queue_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcmq_pkg::*;

    localparam int NUM_CH     = 4;
    localparam int DEPTH      = 16;
    localparam int MAX_WAIT   = 15;
    localparam int RAND_ITEMS = 1800;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 8;
    localparam int CI_W       = $clog2(NUM_CH);
    localparam int SLOT_W     = $clog2(NUM_CH * DEPTH);

    // One result as the block reports it.
    typedef struct packed {
        t_status    status;
        logic [3:0] channel;
        logic [7:0] message;
    } t_msg_result;

    // One row of the directed table; a row may repeat with the message counting up.
    typedef struct packed {
        logic       kind;
        logic [3:0] channel;
        logic [7:0] message;
        logic [7:0] reps;
        logic       typed;
        t_status    exp_status;
        logic [7:0] exp_message;
    } t_dir_row;

    localparam int DIR_ROWS = 15;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Receive on an empty channel straight after reset waits.
        '{KIND_RECEIVE, 4'd0,  8'h00, 8'd1,  1'b1, ST_WAITING,      8'h00},
        // A send then goes straight to the waiting receiver.
        '{KIND_SEND,    4'd0,  8'hFF, 8'd1,  1'b1, ST_DELIVERED,    8'hFF},
        // Channels beyond the count are rejected.
        '{KIND_SEND,    4'd15, 8'hAA, 8'd1,  1'b1, ST_BAD_CHANNEL,  8'h00},
        '{KIND_RECEIVE, 4'd4,  8'h00, 8'd1,  1'b1, ST_BAD_CHANNEL,  8'h00},
        '{KIND_SEND,    4'd8,  8'h00, 8'd1,  1'b1, ST_BAD_CHANNEL,  8'h00},
        // Simple queue and pop of a zero byte.
        '{KIND_SEND,    4'd3,  8'h00, 8'd1,  1'b1, ST_QUEUED,       8'h00},
        '{KIND_RECEIVE, 4'd3,  8'h00, 8'd1,  1'b1, ST_DELIVERED,    8'h00},
        // Fill a queue, overflow it, then drain it so the pointers wrap.
        '{KIND_SEND,    4'd2,  8'h01, 8'd16, 1'b0, ST_QUEUED,       8'h00},
        '{KIND_SEND,    4'd2,  8'h77, 8'd1,  1'b1, ST_QUEUE_FULL,   8'h00},
        '{KIND_RECEIVE, 4'd2,  8'h00, 8'd16, 1'b0, ST_DELIVERED,    8'h00},
        // Pile up waiting receivers to the limit and one beyond.
        '{KIND_RECEIVE, 4'd1,  8'h00, 8'd15, 1'b1, ST_WAITING,      8'h00},
        '{KIND_RECEIVE, 4'd1,  8'h00, 8'd1,  1'b1, ST_WAITERS_FULL, 8'h00},
        '{KIND_SEND,    4'd1,  8'h80, 8'd15, 1'b0, ST_DELIVERED,    8'h00},
        // A few more past the wrap point.
        '{KIND_SEND,    4'd2,  8'h55, 8'd3,  1'b0, ST_QUEUED,       8'h00},
        '{KIND_RECEIVE, 4'd2,  8'h00, 8'd3,  1'b0, ST_DELIVERED,    8'h00}
    };

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // Own copy of the queue state.
    logic [7:0] shadow_store [NUM_CH*DEPTH];
    logic [3:0] shadow_rd_ptr [NUM_CH];
    logic [3:0] shadow_wr_ptr [NUM_CH];
    logic [4:0] shadow_fill [NUM_CH];
    logic [3:0] shadow_waiters [NUM_CH];

    t_msg_result pending_results [$];

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned status_hits [6];
    int unsigned idle_cycles   = 0;

    multi_channel_message_queue_unit #(
        .CHANNELS    (NUM_CH),
        .QUEUE_DEPTH (DEPTH),
        .MAX_WAITERS (MAX_WAIT)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Works out the result of one operation and updates the shadow queues.
    function automatic t_msg_result apply_queue_op(input logic kind, input logic [3:0] ch,
                                                   input logic [7:0] msg);
        t_msg_result       res;
        logic [SLOT_W-1:0] slot;
        logic [CI_W-1:0]   ci;
        res.channel = ch;
        res.message = '0;
        ci          = ch[CI_W-1:0];
        if (ch >= NUM_CH) begin
            res.status = ST_BAD_CHANNEL;
        end else if (kind == KIND_SEND) begin
            if (shadow_waiters[ci] != 0) begin
                shadow_waiters[ci] = shadow_waiters[ci] - 4'd1;
                res.status  = ST_DELIVERED;
                res.message = msg;
            end else if (shadow_fill[ci] >= DEPTH) begin
                res.status = ST_QUEUE_FULL;
            end else begin
                slot = {ci, shadow_wr_ptr[ci]};
                shadow_store[slot] = msg;
                shadow_wr_ptr[ci]  = (shadow_wr_ptr[ci] == DEPTH - 1) ? '0
                                                                      : shadow_wr_ptr[ci] + 4'd1;
                shadow_fill[ci]    = shadow_fill[ci] + 5'd1;
                res.status = ST_QUEUED;
            end
        end else begin
            if (shadow_fill[ci] != 0) begin
                slot = {ci, shadow_rd_ptr[ci]};
                res.message       = shadow_store[slot];
                shadow_rd_ptr[ci] = (shadow_rd_ptr[ci] == DEPTH - 1) ? '0
                                                                     : shadow_rd_ptr[ci] + 4'd1;
                shadow_fill[ci]   = shadow_fill[ci] - 5'd1;
                res.status = ST_DELIVERED;
            end else if (shadow_waiters[ci] >= MAX_WAIT) begin
                res.status = ST_WAITERS_FULL;
            end else begin
                shadow_waiters[ci] = shadow_waiters[ci] + 4'd1;
                res.status = ST_WAITING;
            end
        end
        return res;
    endfunction

    // Offers one operation, waits for its transaction and records what should come back.
    task automatic offer_op(input logic kind, input logic [3:0] ch, input logic [7:0] msg,
                            input logic typed, input t_msg_result typed_res);
        t_msg_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, msg, ch};
        do @(posedge i_clk); while (!s_tready);
        res = apply_queue_op(kind, ch, msg);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        items_sent++;
    endtask

    // Pauses the sender until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic: mostly fill and drain bursts on valid channels, some mixed and noise.
    task automatic run_random(input int n_items, input int src_pct, input int sink_pct);
        int          pick;
        int          n_send;
        int          n_recv;
        logic [3:0]  ch;
        int          stop_at;
        t_msg_result none;
        none = '0;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            ch   = 4'($urandom_range(NUM_CH - 1));
            if (pick < 70) begin
                n_send = $urandom_range(1, DEPTH + 2);
                n_recv = $urandom_range(1, DEPTH + 2);
                if ($urandom_range(1) == 0) begin
                    repeat (n_send)
                        offer_op(KIND_SEND, ch, 8'($urandom_range(255)), 1'b0, none);
                    repeat (n_recv)
                        offer_op(KIND_RECEIVE, ch, 8'($urandom_range(255)), 1'b0, none);
                end else begin
                    repeat (n_recv)
                        offer_op(KIND_RECEIVE, ch, 8'($urandom_range(255)), 1'b0, none);
                    repeat (n_send)
                        offer_op(KIND_SEND, ch, 8'($urandom_range(255)), 1'b0, none);
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8))
                    offer_op(1'($urandom_range(1)), ch, 8'($urandom_range(255)), 1'b0, none);
            end else begin
                offer_op(1'($urandom_range(1)), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 1'b0, none);
            end
        end
    endtask

    // Result side: check each transaction against the oldest expectation, then pick ready.
    always @(posedge i_clk) begin
        t_msg_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser < 6) status_hits[m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d channel %0d message %0h",
                       m_tuser, m_tdata[3:0], m_tdata[11:4]);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[3:0] !== want.channel) begin
                    $error("out_channel: expected %0d, got %0d", want.channel, m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[11:4] !== want.message) begin
                    $error("out_message: expected %0h, got %0h", want.message, m_tdata[11:4]);
                    fail_count++;
                end
                if (m_tdata[15:12] !== 4'd0) begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[15:12]);
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
                $display("multi_channel_message_queue_unit_test: FAIL");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        t_msg_result typed_res;
        t_dir_row    row;
        for (int c = 0; c < NUM_CH; c++) begin
            shadow_rd_ptr[c]  = '0;
            shadow_wr_ptr[c]  = '0;
            shadow_fill[c]    = '0;
            shadow_waiters[c] = '0;
        end
        for (int s = 0; s < 6; s++) status_hits[s] = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, with light idling on both sides.
        src_idle_pct  = 13;
        sink_idle_pct = 13;
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = DIR_TABLE[r];
            for (int k = 0; k < row.reps; k++) begin
                typed_res.status  = row.exp_status;
                typed_res.channel = row.channel;
                typed_res.message = row.exp_message;
                offer_op(row.kind, row.channel, row.message + k[7:0], row.typed, typed_res);
            end
        end
        drain_results();

        // Random traffic in three idling phases, the sender waiting for a drain in between.
        run_random(RAND_ITEMS / 3, 13, 63);
        drain_results();
        run_random(RAND_ITEMS / 3, 63, 13);
        drain_results();
        run_random(RAND_ITEMS / 3, 0, 0);
        drain_results();

        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items, checked %0d results over the table and three idling phases.",
                 items_sent, results_seen);
        $display("Delivered %0d, queued %0d, waiting %0d, bad %0d, full %0d, waiters full %0d.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("multi_channel_message_queue_unit_test: PASS");
        end else begin
            $display("multi_channel_message_queue_unit_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: multi_channel_message_queue_unit.f
+incdir+rtl/core
rtl/core/mcmq_pkg.sv
rtl/core/mcmq_ctrl.sv
rtl/core/mcmq_datapath.sv
rtl/core/multi_channel_message_queue_unit.sv
tb/multi_channel_message_queue_unit_test.sv
